@@ design/mrgm_pkg.sv @@
package mrgm_pkg;

   // mesh geometry
   localparam int MAX_DIMS       = 8;
   localparam int RANK_BITS      = 16;
   localparam int DIM_SIZE_BITS  = 8;

   // fixed register and field widths
   localparam int SELF_RANK_BITS = 16;
   localparam int NUM_DIMS_BITS  = 4;
   localparam int SIZES_BITS     = 64;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 2;
   localparam int ENTRY_BITS     = 8;
   localparam int CAND_BITS      = 16;

   localparam int DIM_IDX_BITS   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int DIM_CNT_BITS   = $clog2(MAX_DIMS + 1);

   // divider: quotient bits retired per cycle
   localparam int BITS_PER_STEP     = 4;
   localparam int DIV_STEPS         = (RANK_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int DIV_PAD_BITS      = DIV_STEPS * BITS_PER_STEP;
   localparam int DIV_STEP_CNT_BITS = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SELF_RANK = 2'd0,
      CSR_NUM_DIMS  = 2'd1,
      CSR_DIM_SIZES = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_MAP_ENTRY = 1'b0,
      OP_CANDIDATE = 1'b1
   } op_type;

   localparam logic signed [ENTRY_BITS-1:0] MAP_NOT_SPLIT = -8'sd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIGIT,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                          operation;
      logic signed [ENTRY_BITS-1:0]  map_entry;
      logic [CAND_BITS-1:0]          candidate_rank;
      logic                          last_candidate;
   } req_type;

   typedef struct packed {
      logic [CAND_BITS-1:0] rank_out;
      logic                 matched;
      logic                 map_invalid;
      logic                 shape_invalid;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic                     start;
      logic [DIM_SIZE_BITS-1:0] divisor;
      logic [RANK_BITS-1:0]     dividend_a;
      logic [RANK_BITS-1:0]     dividend_b;
   } div_cmd_type;

   typedef struct packed {
      logic                     done;
      logic [RANK_BITS-1:0]     quot_a;
      logic [RANK_BITS-1:0]     quot_b;
      logic [DIM_SIZE_BITS-1:0] rem_a;
      logic [DIM_SIZE_BITS-1:0] rem_b;
   } div_rsp_type;

   function automatic logic [DIM_CNT_BITS-1:0] dims_in_use(
      input logic [NUM_DIMS_BITS-1:0] n
   );
      return (int'(n) > MAX_DIMS) ? DIM_CNT_BITS'(MAX_DIMS) : DIM_CNT_BITS'(n);
   endfunction

   // sizes past the top of the register read as zero
   function automatic logic [DIM_SIZE_BITS-1:0] dim_size(
      input logic [SIZES_BITS-1:0]   sizes,
      input logic [DIM_IDX_BITS-1:0] d
   );
      logic [SIZES_BITS-1:0] sh;
      sh = sizes >> (DIM_SIZE_BITS * int'(d));
      return sh[DIM_SIZE_BITS-1:0];
   endfunction

endpackage

@@ design/mrgm_divider.sv @@
module mrgm_divider
   import mrgm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_rsp_type sts
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [DIV_STEP_CNT_BITS-1:0] step_ff, step_in;
   logic [DIM_SIZE_BITS-1:0]     divisor_ff, divisor_in;
   logic [DIV_PAD_BITS-1:0]      dvd_a_ff, dvd_a_in, dvd_b_ff, dvd_b_in;
   logic [DIM_SIZE_BITS-1:0]     rem_a_ff, rem_a_in, rem_b_ff, rem_b_in;
   logic [DIV_PAD_BITS-1:0]      nxt_dvd_a, nxt_dvd_b;
   logic [DIM_SIZE_BITS-1:0]     nxt_rem_a, nxt_rem_b;

   // BITS_PER_STEP restoring steps; quotient bits shift in where dividend bits leave
   function automatic logic [DIV_PAD_BITS+DIM_SIZE_BITS-1:0] div_steps(
      input logic [DIV_PAD_BITS-1:0]  dvd,
      input logic [DIM_SIZE_BITS-1:0] rem,
      input logic [DIM_SIZE_BITS-1:0] dsr
   );
      logic [DIV_PAD_BITS-1:0]  q;
      logic [DIM_SIZE_BITS-1:0] r;
      logic [DIM_SIZE_BITS:0]   t;
      q = dvd;
      r = rem;
      for (int i = 0; i < BITS_PER_STEP; i++) begin
         t = {r, q[DIV_PAD_BITS-1]};
         q = {q[DIV_PAD_BITS-2:0], 1'b0};
         if (t >= {1'b0, dsr}) begin
            t    = t - {1'b0, dsr};
            q[0] = 1'b1;
         end
         r = t[DIM_SIZE_BITS-1:0];
      end
      return {q, r};
   endfunction

   always_comb begin
      {nxt_dvd_a, nxt_rem_a} = div_steps(dvd_a_ff, rem_a_ff, divisor_ff);
      {nxt_dvd_b, nxt_rem_b} = div_steps(dvd_b_ff, rem_b_ff, divisor_ff);
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      divisor_in = divisor_ff;
      dvd_a_in   = dvd_a_ff;
      dvd_b_in   = dvd_b_ff;
      rem_a_in   = rem_a_ff;
      rem_b_in   = rem_b_ff;
      if (!busy_ff && cmd.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         divisor_in = cmd.divisor;
         dvd_a_in   = DIV_PAD_BITS'(cmd.dividend_a);
         dvd_b_in   = DIV_PAD_BITS'(cmd.dividend_b);
         rem_a_in   = '0;
         rem_b_in   = '0;
      end else if (busy_ff) begin
         dvd_a_in = nxt_dvd_a;
         dvd_b_in = nxt_dvd_b;
         rem_a_in = nxt_rem_a;
         rem_b_in = nxt_rem_b;
         step_in  = step_ff + 1'b1;
         if (int'(step_ff) == DIV_STEPS - 1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      dvd_a_ff   <= dvd_a_in;
      dvd_b_ff   <= dvd_b_in;
      rem_a_ff   <= rem_a_in;
      rem_b_ff   <= rem_b_in;
   end

   assign sts.done   = done_ff;
   assign sts.quot_a = dvd_a_ff[RANK_BITS-1:0];
   assign sts.quot_b = dvd_b_ff[RANK_BITS-1:0];
   assign sts.rem_a  = rem_a_ff;
   assign sts.rem_b  = rem_b_ff;

endmodule

@@ design/mesh_rank_group_match_unit.sv @@
// channel   ports                          direction  carries
// req       req_valid req_stall req_data   in         map entry or candidate rank
// rsp       rsp_valid rsp_stall rsp_data   out        one result per candidate
// csr       csr_we csr_index csr_wdata     in         register write, no wait
//
// a map entry is taken without stalling and yields no result
// a candidate yields one digit per dimension in use, and each nonzero-size digit runs
// through the shared divider, 4 quotient bits a cycle; a zero-size digit skips the divider
// req_stall stays high from candidate accept until its result is in the output register
// a held result does not block map entries; reset is synchronous and clears the mask
module mesh_rank_group_match_unit
   import mrgm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   state_type state_ff, state_in;

   logic [SELF_RANK_BITS-1:0] self_rank_ff;
   logic [NUM_DIMS_BITS-1:0]  num_dims_ff;
   logic [SIZES_BITS-1:0]     dim_sizes_ff;

   logic [MAX_DIMS-1:0]     split_mask_ff, split_mask_in;
   logic                    map_bad_ff, map_bad_in;
   logic [RANK_BITS-1:0]    own_ff, own_in, cand_ff, cand_in;
   logic [CAND_BITS-1:0]    rank_ff, rank_in;
   logic                    last_ff, last_in;
   logic [DIM_CNT_BITS-1:0] k_ff, k_in, nd_ff, nd_in;
   logic                    match_ff, match_in;
   logic                    shape_bad_ff, shape_bad_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                     req_take, emit, digit_left, entry_bad;
   logic [DIM_CNT_BITS-1:0]  nd_now, dim_sel;
   logic [DIM_SIZE_BITS-1:0] size_cur;
   div_cmd_type              div_cmd;
   div_rsp_type              div_sts;

   mrgm_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign nd_now     = dims_in_use(num_dims_ff);
   assign digit_left = (k_ff < nd_ff);
   // digit k counts from the least significant dimension
   assign dim_sel    = nd_ff - 1'b1 - k_ff;
   assign size_cur   = dim_size(dim_sizes_ff, dim_sel[DIM_IDX_BITS-1:0]);
   assign emit       = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign entry_bad = req_data.map_entry[ENTRY_BITS-1]
                      || (ENTRY_BITS'(req_data.map_entry[ENTRY_BITS-2:0])
                          >= ENTRY_BITS'(nd_now));

   assign div_cmd.start      = (state_ff == ST_DIGIT) && digit_left && (size_cur != '0);
   assign div_cmd.divisor    = size_cur;
   assign div_cmd.dividend_a = own_ff;
   assign div_cmd.dividend_b = cand_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_data.operation == OP_CANDIDATE) state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            if (!digit_left) state_in = ST_DONE;
            else if (size_cur != '0) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_sts.done) state_in = ST_DIGIT;
         end
         ST_DONE: begin
            if (emit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      split_mask_in = split_mask_ff;
      map_bad_in    = map_bad_ff;
      own_in        = own_ff;
      cand_in       = cand_ff;
      rank_in       = rank_ff;
      last_in       = last_ff;
      k_in          = k_ff;
      nd_in         = nd_ff;
      match_in      = match_ff;
      shape_bad_in  = shape_bad_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.operation == OP_CANDIDATE) begin
                  own_in       = RANK_BITS'(self_rank_ff);
                  cand_in      = RANK_BITS'(req_data.candidate_rank);
                  rank_in      = CAND_BITS'(RANK_BITS'(req_data.candidate_rank));
                  last_in      = req_data.last_candidate;
                  k_in         = '0;
                  nd_in        = nd_now;
                  match_in     = 1'b1;
                  shape_bad_in = 1'b0;
               end else if (req_data.map_entry != MAP_NOT_SPLIT) begin
                  if (entry_bad) begin
                     map_bad_in = 1'b1;
                  end else begin
                     split_mask_in = split_mask_ff
                        | (MAX_DIMS'(1) << req_data.map_entry[DIM_IDX_BITS-1:0]);
                  end
               end
            end
         end
         ST_DIGIT: begin
            if (digit_left && size_cur == '0) begin
               shape_bad_in = 1'b1;
               k_in         = k_ff + 1'b1;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               if (split_mask_ff[k_ff[DIM_IDX_BITS-1:0]] && div_sts.rem_a != div_sts.rem_b)
                  match_in = 1'b0;
               own_in  = div_sts.quot_a;
               cand_in = div_sts.quot_b;
               k_in    = k_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (emit) begin
               rsp_valid_in         = 1'b1;
               rsp_in.rank_out      = rank_ff;
               rsp_in.matched       = match_ff && !shape_bad_ff && !map_bad_ff;
               rsp_in.map_invalid   = map_bad_ff;
               rsp_in.shape_invalid = shape_bad_ff;
               rsp_in.last          = last_ff;
               if (last_ff) begin
                  split_mask_in = '0;
                  map_bad_in    = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         split_mask_ff <= '0;
         map_bad_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         self_rank_ff  <= '0;
         num_dims_ff   <= NUM_DIMS_BITS'(1);
         dim_sizes_ff  <= SIZES_BITS'(1);
      end else begin
         state_ff      <= state_in;
         split_mask_ff <= split_mask_in;
         map_bad_ff    <= map_bad_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SELF_RANK: self_rank_ff <= csr_wdata[SELF_RANK_BITS-1:0];
               CSR_NUM_DIMS:  num_dims_ff  <= csr_wdata[NUM_DIMS_BITS-1:0];
               CSR_DIM_SIZES: dim_sizes_ff <= csr_wdata[SIZES_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      own_ff       <= own_in;
      cand_ff      <= cand_in;
      rank_ff      <= rank_in;
      last_ff      <= last_in;
      k_ff         <= k_in;
      nd_ff        <= nd_in;
      match_ff     <= match_in;
      shape_bad_ff <= shape_bad_in;
      rsp_ff       <= rsp_in;
   end

endmodule

@@ design/mrgm_checker.sv @@
module mrgm_checker
   import mrgm_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input req_type                   req_data,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input rsp_type                   rsp_data,
   input logic                      csr_we,
   input logic [CSR_INDEX_BITS-1:0] csr_index,
   input logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // a candidate occupies the unit for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.operation == OP_CANDIDATE |=> req_stall)
      else $error("candidate accepted without going busy");

   // a map entry never stalls the channel
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.operation == OP_MAP_ENTRY |=> !req_stall)
      else $error("map entry left the unit busy");

   // a fresh result only appears at the end of a candidate
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a candidate in flight");

   // an invalid flag forces no match
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.map_invalid || rsp_data.shape_invalid) |-> !rsp_data.matched)
      else $error("match reported with invalid map or shape");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

endmodule

bind mesh_rank_group_match_unit mrgm_checker u_mrgm_checker (.*);
